FILE: design/tbsr_pkg.sv
// Shared types and constants of the byte stream reassembler.
package tbsr_pkg;

   localparam int INDEX_W = 32;
   localparam int END_W = 33;
   localparam int LEN_W = 16;
   localparam int BYTE_W = 8;
   localparam int SPACE_W = 6;
   localparam int PEND_W = 6;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 16;

   localparam logic [END_W-1:0] END_UNKNOWN = {END_W{1'b1}};

   typedef enum logic [1:0] {
      K_BYTE   = 2'd0,
      K_EOS    = 2'd1,
      K_ERROR  = 2'd2,
      K_STATUS = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [BYTE_W-1:0]     out_byte;
      logic [PEND_W-1:0]     pending;
   } result_type;

endpackage

FILE: design/tcp_byte_stream_reassembler_unit.sv
// Top level of the byte stream reassembler: sequencer, valid bits and counters.
//
//  channel | ports            | moves
//  --------+------------------+------------------------------------------------
//  req     | req_t*           | one segment byte with its index, length, eof
//  rsp     | rsp_t*           | byte, end of stream, error or status results
//
// Each item steps through accept, place, final scan and status; each delivered byte
// adds a valid check with byte store read, then the transfer. A duplicate check and an
// end of stream step are added when they occur. A segment beyond the window goes
// from accept straight to status. The byte store read is registered, so each delivered
// byte needs its own transfer step. Reset is synchronous and clears the valid bits at
// once. A stalled result port holds the sequencer in its emitting state.
module tcp_byte_stream_reassembler_unit #(
   parameter int BUFFER_BYTES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // seg_index [31:0], seg_len [47:32], byte_offset [63:48],
   // byte_value [71:64], out_space [77:72], zero [79:78]
   input  logic [tbsr_pkg::REQ_DATA_W-1:0] req_tdata,
   // has_byte [0]
   input  logic                            req_tuser,
   // seg_eof
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_byte [7:0], pending [13:8], zero [15:14]
   output logic [tbsr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind [1:0]
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int SLOT_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
   localparam int SUM_W = $clog2(2 * BUFFER_BYTES);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BUFFER_BYTES - 1);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(BUFFER_BYTES);
   localparam logic [tbsr_pkg::SPACE_W-1:0] DEPTH_SPACE =
      tbsr_pkg::SPACE_W'(BUFFER_BYTES);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_PLACE  = 7'b0000010,
      S_DUP    = 7'b0000100,
      S_SCAN   = 7'b0001000,
      S_BYTE   = 7'b0010000,
      S_EOS    = 7'b0100000,
      S_STATUS = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [tbsr_pkg::INDEX_W-1:0] next_index_ff, next_index_in;
   logic [tbsr_pkg::END_W-1:0]   end_index_ff, end_index_in;
   logic [BUFFER_BYTES-1:0]      valid_ff, valid_in;
   logic [CNT_W-1:0]             pending_ff, pending_in;
   logic [SLOT_W-1:0]            head_ff, head_in;
   logic                         store_ok_ff, store_ok_in;
   logic [CNT_W-1:0]             dist_ff, dist_in;
   logic [tbsr_pkg::BYTE_W-1:0]  byte_ff, byte_in;

   // request fields
   logic [tbsr_pkg::INDEX_W-1:0] seg_index;
   logic [tbsr_pkg::LEN_W-1:0]   seg_len;
   logic [tbsr_pkg::LEN_W-1:0]   byte_offset;
   logic [tbsr_pkg::BYTE_W-1:0]  byte_value;
   logic [tbsr_pkg::SPACE_W-1:0] out_space;

   logic                         accept;
   logic [CNT_W-1:0]             space;
   logic [tbsr_pkg::END_W-1:0]   next_ext;
   logic [tbsr_pkg::END_W-1:0]   limit;
   logic [tbsr_pkg::END_W-1:0]   pos;
   logic                         drop;
   logic [SUM_W-1:0]             slot_sum;
   logic [SLOT_W-1:0]            place_slot;
   logic                         scan_take;

   logic                         wr_en;
   logic                         rd_en;
   logic [SLOT_W-1:0]            rd_addr;
   logic [tbsr_pkg::BYTE_W-1:0]  rd_data;

   logic                         push;
   tbsr_pkg::result_type         push_data;
   logic                         can_push;

   assign seg_index   = req_tdata[31:0];
   assign seg_len     = req_tdata[47:32];
   assign byte_offset = req_tdata[63:48];
   assign byte_value  = req_tdata[71:64];
   assign out_space   = req_tdata[77:72];

   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;

   // window arithmetic on the incoming item
   assign space = (out_space > DEPTH_SPACE) ? CNT_W'(BUFFER_BYTES) : CNT_W'(out_space);
   assign next_ext = {1'b0, next_index_ff};
   assign limit = next_ext + tbsr_pkg::END_W'(space);
   assign pos = tbsr_pkg::END_W'(seg_index) + tbsr_pkg::END_W'(byte_offset);
   assign drop = (tbsr_pkg::END_W'(seg_index) >= limit);

   // ring slot of the stored byte: head plus distance, folded once
   assign slot_sum = SUM_W'(head_ff) + SUM_W'(dist_ff);
   assign place_slot = (slot_sum >= DEPTH_SUM) ? SLOT_W'(slot_sum - DEPTH_SUM)
                                               : SLOT_W'(slot_sum);

   assign scan_take = (next_ext < end_index_ff) && valid_ff[head_ff];

   always_comb begin
      state_in      = state_ff;
      next_index_in = next_index_ff;
      end_index_in  = end_index_ff;
      valid_in      = valid_ff;
      pending_in    = pending_ff;
      head_in       = head_ff;
      store_ok_in   = store_ok_ff;
      dist_in       = dist_ff;
      byte_in       = byte_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = place_slot;
      push          = 1'b0;
      push_data.kind     = tbsr_pkg::K_STATUS;
      push_data.out_byte = '0;
      push_data.pending  = tbsr_pkg::PEND_W'(pending_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               store_ok_in = req_tuser && (byte_offset < seg_len) &&
                             (pos >= next_ext) && (pos < limit);
               dist_in = CNT_W'(pos - next_ext);
               byte_in = byte_value;
               if (drop) begin
                  state_in = S_STATUS;
               end else begin
                  if (req_tlast) begin
                     end_index_in = tbsr_pkg::END_W'(seg_index) +
                                    tbsr_pkg::END_W'(seg_len);
                  end
                  state_in = S_PLACE;
               end
            end
         end
         S_PLACE: begin
            if (store_ok_ff && valid_ff[place_slot]) begin
               // occupied: fetch the stored byte for comparison
               rd_en = 1'b1;
               state_in = S_DUP;
            end else begin
               if (store_ok_ff) begin
                  wr_en = 1'b1;
                  valid_in[place_slot] = 1'b1;
                  pending_in = pending_ff + 1'b1;
               end
               state_in = S_SCAN;
            end
         end
         S_DUP: begin
            if (rd_data != byte_ff) begin
               push_data.kind = tbsr_pkg::K_ERROR;
               if (can_push) begin
                  push = 1'b1;
                  state_in = S_SCAN;
               end
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_addr = head_ff;
            if (scan_take) begin
               rd_en = 1'b1;
               valid_in[head_ff] = 1'b0;
               pending_in = pending_ff - 1'b1;
               next_index_in = next_index_ff + 1'b1;
               // the ring position restarts after the last slot and when the stream index wraps
               if (next_index_ff == {tbsr_pkg::INDEX_W{1'b1}} || head_ff == LAST_SLOT) begin
                  head_in = '0;
               end else begin
                  head_in = head_ff + 1'b1;
               end
               state_in = S_BYTE;
            end else if (next_ext == end_index_ff) begin
               state_in = S_EOS;
            end else begin
               state_in = S_STATUS;
            end
         end
         S_BYTE: begin
            push_data.kind = tbsr_pkg::K_BYTE;
            push_data.out_byte = rd_data;
            if (can_push) begin
               push = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_EOS: begin
            push_data.kind = tbsr_pkg::K_EOS;
            if (can_push) begin
               push = 1'b1;
               state_in = S_STATUS;
            end
         end
         S_STATUS: begin
            push_data.kind = tbsr_pkg::K_STATUS;
            if (can_push) begin
               push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_index_ff <= '0;
         end_index_ff  <= tbsr_pkg::END_UNKNOWN;
         valid_ff      <= '0;
         pending_ff    <= '0;
         head_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         next_index_ff <= next_index_in;
         end_index_ff  <= end_index_in;
         valid_ff      <= valid_in;
         pending_ff    <= pending_in;
         head_ff       <= head_in;
      end
      store_ok_ff <= store_ok_in;
      dist_ff     <= dist_in;
      byte_ff     <= byte_in;
   end

   tbsr_mem #(
      .DEPTH  (BUFFER_BYTES),
      .ADDR_W (SLOT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (place_slot),
      .wr_data (byte_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tbsr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .can_push   (can_push),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_pending_matches_valid: assert property (@(posedge clock) disable iff (reset)
      pending_ff == CNT_W'($countones(valid_ff)))
      else $error("pending count differs from number of valid entries");

   a_push_into_free: assert property (@(posedge clock) disable iff (reset)
      push |-> can_push)
      else $error("result pushed into an occupied result register");

   a_drain_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && scan_take) |=>
         (next_index_ff == $past(next_index_ff) + 1'b1 && state_ff == S_BYTE))
      else $error("drain step did not advance the stream index by one");

   a_eos_reached: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EOS) |-> (next_ext == end_index_ff))
      else $error("end of stream reported before the end index");
`endif

endmodule

FILE: design/tbsr_mem.sv
// Byte store: one write port, one read port with registered read data.
module tbsr_mem #(
   parameter int DEPTH = 32,
   parameter int ADDR_W = 5
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [tbsr_pkg::BYTE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [tbsr_pkg::BYTE_W-1:0] rd_data
);

   logic [tbsr_pkg::BYTE_W-1:0] byte_store [DEPTH];
   logic [tbsr_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= byte_store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/tbsr_out.sv
// Result register: holds one result until the downstream side takes it.
module tbsr_out (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  tbsr_pkg::result_type            push_data,
   output logic                            can_push,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_byte [7:0], pending [13:8], zero [15:14]
   output logic [tbsr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind [1:0]
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast
);

   logic                 valid_ff;
   logic                 valid_in;
   tbsr_pkg::result_type data_ff;

   assign can_push = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {2'b00, data_ff.pending, data_ff.out_byte};
   assign rsp_tuser = data_ff.kind;
   assign rsp_tlast = (data_ff.kind == tbsr_pkg::K_STATUS);

endmodule

FILE: bench/tcp_byte_stream_reassembler_unit_tb.sv
// Self-checking bench for the byte stream reassembler: directed table, then random segment streams.
`timescale 1ns / 1ps

module tcp_byte_stream_reassembler_unit_tb;

   localparam int BUFFER_BYTES = 32;
   localparam int STREAM_ITEMS = 400;
   localparam int HOLD_AT = 120;
   localparam int PAUSE_AT = 260;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 100;
   localparam int IDLE_LIMIT = 4000;
   localparam int DIR_ROWS = 19;

   typedef struct packed {
      logic [31:0] seg_index;
      logic [15:0] seg_len;
      logic [15:0] byte_offset;
      logic [7:0]  byte_value;
      logic        has_byte;
      logic        seg_eof;
      logic [5:0]  out_space;
   } seg_item_type;

   typedef struct packed {
      tbsr_pkg::kind_type kind;
      logic [7:0]  out_byte;
      logic [5:0]  pending;
      logic        last;
   } rsp_item_type;

   // fixed set: the item yields only a status whose pending count is pend
   typedef struct packed {
      seg_item_type item;
      logic        fixed;
      logic [5:0]  pend;
   } dir_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [tbsr_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [tbsr_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   // shadow state of the reassembler
   logic [31:0] ra_next;
   logic [32:0] ra_end;
   logic [7:0]  ra_store [0:BUFFER_BYTES-1];
   logic        ra_valid [0:BUFFER_BYTES-1];
   logic [5:0]  ra_pending;

   rsp_item_type expected_results [$];
   rsp_item_type item_results [$];
   bit item_live;
   int sent_items = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   bit hold_results = 1'b0;

   dir_row_type dir_rows [0:DIR_ROWS-1] = '{
      // beyond window at every extreme, eof ignored
      '{'{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 6'd63}, 1'b1, 6'd0},
      '{'{32'd32, 16'd1, 16'd0, 8'h5A, 1'b1, 1'b1, 6'd32}, 1'b1, 6'd0},
      '{'{32'd0, 16'd1, 16'd0, 8'h5A, 1'b1, 1'b0, 6'd0}, 1'b1, 6'd0},
      // store out of order, then conflicting and equal duplicates
      '{'{32'd0, 16'd4, 16'd2, 8'hAA, 1'b1, 1'b0, 6'd32}, 1'b1, 6'd1},
      '{'{32'd0, 16'd4, 16'd2, 8'h55, 1'b1, 1'b0, 6'd32}, 1'b0, 6'd0},
      '{'{32'd0, 16'd4, 16'd2, 8'hAA, 1'b1, 1'b0, 6'd32}, 1'b1, 6'd1},
      // offset past segment, past window, at window edge, no byte
      '{'{32'd0, 16'd2, 16'd2, 8'h77, 1'b1, 1'b0, 6'd32}, 1'b1, 6'd1},
      '{'{32'd0, 16'd100, 16'd40, 8'h77, 1'b1, 1'b0, 6'd32}, 1'b1, 6'd1},
      '{'{32'd0, 16'd100, 16'd5, 8'h77, 1'b1, 1'b0, 6'd5}, 1'b1, 6'd1},
      '{'{32'd0, 16'd0, 16'd0, 8'h00, 1'b0, 1'b0, 6'd32}, 1'b1, 6'd1},
      // fill the gap and drain, then close the stream
      '{'{32'd0, 16'd4, 16'd0, 8'h00, 1'b1, 1'b0, 6'd32}, 1'b0, 6'd0},
      '{'{32'd0, 16'd4, 16'd1, 8'h11, 1'b1, 1'b0, 6'd32}, 1'b0, 6'd0},
      '{'{32'd0, 16'd4, 16'd3, 8'hFF, 1'b1, 1'b1, 6'd32}, 1'b0, 6'd0},
      '{'{32'd0, 16'd4, 16'd1, 8'h11, 1'b1, 1'b0, 6'd32}, 1'b0, 6'd0},
      // bare eof moves the end away
      '{'{32'd4, 16'd10, 16'd0, 8'h00, 1'b0, 1'b1, 6'd32}, 1'b1, 6'd0},
      // space above the ring is clamped
      '{'{32'd4, 16'd40, 16'd35, 8'hC3, 1'b1, 1'b0, 6'd63}, 1'b1, 6'd0},
      '{'{32'd4, 16'd40, 16'd31, 8'h3C, 1'b1, 1'b0, 6'd63}, 1'b1, 6'd1},
      '{'{32'd4, 16'd40, 16'd1, 8'h81, 1'b1, 1'b0, 6'd1}, 1'b1, 6'd1},
      '{'{32'd4, 16'd1, 16'd0, 8'hE7, 1'b1, 1'b1, 6'd1}, 1'b0, 6'd0}
   };

   tcp_byte_stream_reassembler_unit #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rsp_item_type make_rsp(tbsr_pkg::kind_type k, logic [7:0] b,
                                             logic [5:0] p, logic l);
      rsp_item_type r;
      r.kind = k;
      r.out_byte = b;
      r.pending = p;
      r.last = l;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Work out the results of one accepted item and advance the shadow state.
   task automatic reassemble_item(input seg_item_type it);
      logic [63:0] lim;
      logic [63:0] pos;
      logic [5:0] sp;
      int slot;
      item_results.delete();
      sp = (it.out_space > BUFFER_BYTES) ? 6'(BUFFER_BYTES) : it.out_space;
      lim = 64'(ra_next) + 64'(sp);
      item_live = (64'(it.seg_index) < lim);
      if (!item_live) begin
         item_results.insert(item_results.size(),
                             make_rsp(tbsr_pkg::K_STATUS, 8'd0, ra_pending, 1'b1));
         return;
      end
      if (it.seg_eof)
         ra_end = 33'(it.seg_index) + 33'(it.seg_len);
      if (it.has_byte && it.byte_offset < it.seg_len) begin
         pos = 64'(it.seg_index) + 64'(it.byte_offset);
         if (pos >= 64'(ra_next) && pos < lim) begin
            slot = int'(pos % BUFFER_BYTES);
            if (ra_valid[slot]) begin
               if (ra_store[slot] != it.byte_value)
                  item_results.insert(item_results.size(),
                                      make_rsp(tbsr_pkg::K_ERROR, 8'd0, ra_pending, 1'b0));
            end else begin
               ra_store[slot] = it.byte_value;
               ra_valid[slot] = 1'b1;
               ra_pending = ra_pending + 6'd1;
            end
         end
      end
      while (33'(ra_next) < ra_end) begin
         slot = int'(ra_next % BUFFER_BYTES);
         if (!ra_valid[slot])
            break;
         ra_valid[slot] = 1'b0;
         if (ra_pending > 0)
            ra_pending = ra_pending - 6'd1;
         ra_next = ra_next + 32'd1;
         item_results.insert(item_results.size(),
                             make_rsp(tbsr_pkg::K_BYTE, ra_store[slot], ra_pending, 1'b0));
      end
      if (33'(ra_next) == ra_end)
         item_results.insert(item_results.size(),
                             make_rsp(tbsr_pkg::K_EOS, 8'd0, ra_pending, 1'b0));
      item_results.insert(item_results.size(),
                          make_rsp(tbsr_pkg::K_STATUS, 8'd0, ra_pending, 1'b1));
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [5:0] pick_space();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 6'd32;
      else if (r < 80)
         return 6'($urandom_range(33, 63));
      return 6'($urandom_range(0, 31));
   endfunction

   // Offer one item, wait for its transfer, then queue what it should yield.
   task automatic send_item(input seg_item_type it, input logic fixed, input logic [5:0] pend);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, it.out_space, it.byte_value, it.byte_offset, it.seg_len,
                    it.seg_index};
      req_tuser <= it.has_byte;
      req_tlast <= it.seg_eof;
      do @(posedge clock); while (!req_tready);
      reassemble_item(it);
      if (fixed)
         expected_results.insert(expected_results.size(),
                                 make_rsp(tbsr_pkg::K_STATUS, 8'd0, pend, 1'b1));
      else
         foreach (item_results[k])
            expected_results.insert(expected_results.size(), item_results[k]);
      sent_items++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_noise();
      seg_item_type it;
      bit near;
      near = 1'($urandom_range(0, 1));
      it.seg_index = near ? ra_next + 32'($urandom_range(0, 48)) - 32'd8 : 32'($urandom);
      it.seg_len = near ? 16'($urandom_range(0, 48)) : 16'($urandom_range(0, 65535));
      it.byte_offset = near ? 16'($urandom_range(0, 56)) : 16'($urandom_range(0, 65535));
      it.byte_value = 8'($urandom_range(0, 255));
      it.has_byte = 1'($urandom_range(0, 1));
      it.seg_eof = ($urandom_range(0, 19) == 0);
      it.out_space = 6'($urandom_range(0, 63));
      send_item(it, 1'b0, 6'd0);
   endtask

   // space of -1 picks a fresh space for each byte
   task automatic send_segment(input logic [31:0] base, input int start, input int slen,
                               input int total, input logic [7:0] data [0:63],
                               input int space, input bit corrupt);
      seg_item_type it;
      for (int off = 0; off < slen; off++) begin
         it.seg_index = base + 32'(start);
         it.seg_len = 16'(slen);
         it.byte_offset = 16'(off);
         it.byte_value = data[start + off];
         if (corrupt && $urandom_range(0, 11) == 0)
            it.byte_value = 8'($urandom_range(0, 255));
         it.has_byte = 1'b1;
         it.seg_eof = (start + slen == total);
         it.out_space = (space < 0) ? pick_space() : 6'(space);
         send_item(it, 1'b0, 6'd0);
      end
   endtask

   // One stream from the current delivery point: shuffled segments with
   // duplicates, noise and corruption, then in-order retransmission.
   task automatic run_stream();
      int len, pos, j, t, tries;
      logic [31:0] base;
      logic [7:0] data [0:63];
      int s_start [$];
      int s_len [$];
      int order [$];
      seg_item_type it;
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 40);
      base = ra_next;
      for (int k = 0; k < 64; k++)
         data[k] = 8'($urandom_range(0, 255));
      pos = 0;
      while (pos < len) begin
         t = $urandom_range(1, 8);
         if (pos + t > len)
            t = len - pos;
         s_start.insert(s_start.size(), pos);
         s_len.insert(s_len.size(), t);
         order.insert(order.size(), order.size());
         pos += t;
      end
      for (int k = order.size() - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = order[k];
         order[k] = order[j];
         order[j] = t;
      end
      foreach (order[k]) begin
         send_segment(base, s_start[order[k]], s_len[order[k]], len, data, -1, 1'b1);
         if ($urandom_range(0, 9) == 0)
            send_segment(base, s_start[order[k]], s_len[order[k]], len, data, -1, 1'b1);
         if ($urandom_range(0, 4) == 0)
            send_noise();
      end
      if ($urandom_range(0, 19) == 0) begin
         it = '0;
         it.seg_index = base + 32'(len);
         it.seg_eof = 1'b1;
         it.out_space = pick_space();
         send_item(it, 1'b0, 6'd0);
      end
      tries = 0;
      while (int'(ra_next - base) < len && tries < 3) begin
         foreach (s_start[k])
            if (s_start[k] + s_len[k] > int'(ra_next - base))
               send_segment(base, s_start[k], s_len[k], len, data, 32, 1'b0);
         tries++;
      end
   endtask

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected, kind", rsp_tuser, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("kind", rsp_tuser, want.kind);
            if (rsp_tdata[7:0] !== want.out_byte)
               report_mismatch("out_byte", rsp_tdata[7:0], want.out_byte);
            if (rsp_tdata[13:8] !== want.pending)
               report_mismatch("pending", rsp_tdata[13:8], want.pending);
            if (rsp_tlast !== want.last)
               report_mismatch("last", rsp_tlast, want.last);
         end
      end
   end

   // Result side: random ready stretches, plus one long hold-off on request.
   initial begin : rsp_pacing
      int r;
      wait (!reset);
      forever begin
         if (hold_results) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(1, 16)) @(posedge clock);
            end else if (r < 90) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else if (r < 97) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(10, 60)) @(posedge clock);
            end else begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(50, 150)) @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      wait (!reset);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      bit held, paused;
      held = 1'b0;
      paused = 1'b0;
      ra_next = '0;
      ra_end = tbsr_pkg::END_UNKNOWN;
      ra_pending = '0;
      for (int k = 0; k < BUFFER_BYTES; k++)
         ra_valid[k] = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int row = 0; row < DIR_ROWS; row++)
         send_item(dir_rows[row].item, dir_rows[row].fixed, dir_rows[row].pend);

      while (sent_items < STREAM_ITEMS) begin
         if (!held && sent_items >= HOLD_AT) begin
            // stall the result side while the sender keeps offering
            hold_results = 1'b1;
            held = 1'b1;
         end
         if (!paused && sent_items >= PAUSE_AT) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (expected_results.size() != 0);
            paused = 1'b1;
         end
         run_stream();
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never delivered", expected_results.size(), 0);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
